[rtl/smd_pkg.sv]
package smd_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_FLAG  = 2'd1;
    localparam logic [1:0] OP_DELTA = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Register indexes of the configuration port.
    localparam logic REG_USE_LARGE = 1'b0;
    localparam logic REG_KEEP      = 1'b1;

    // Store geometry.
    localparam int LARGE_LIST_COUNT = 2;
    localparam int STORE_DEPTH      = 224;
    localparam int STORE_AW         = 8;
    localparam int STAGE_DEPTH      = 64;
    localparam int STAGE_AW         = 6;
    localparam logic [3:0] COUNT_SMALL = 4'd6;
    localparam logic [3:0] COUNT_LARGE = 4'(6 + LARGE_LIST_COUNT);
    localparam logic [7:0] FLAT_VALUE  = 8'd16;
    localparam logic [7:0] START_SCALE = 8'd8;

    // Zigzag scans: scan index to raster position.
    localparam logic [3:0] ZZ4 [16] = '{
        4'd0, 4'd1, 4'd4, 4'd8, 4'd5, 4'd2, 4'd3, 4'd6,
        4'd9, 4'd12, 4'd13, 4'd10, 4'd7, 4'd11, 4'd14, 4'd15};

    localparam logic [5:0] ZZ8 [64] = '{
        6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63};

    // Default lists, in scan order.
    localparam logic [7:0] DEF4_INTRA [16] = '{
        8'd6, 8'd13, 8'd13, 8'd20, 8'd20, 8'd20, 8'd28, 8'd28,
        8'd28, 8'd28, 8'd32, 8'd32, 8'd32, 8'd37, 8'd37, 8'd42};

    localparam logic [7:0] DEF4_INTER [16] = '{
        8'd10, 8'd14, 8'd14, 8'd20, 8'd20, 8'd20, 8'd24, 8'd24,
        8'd24, 8'd24, 8'd27, 8'd27, 8'd27, 8'd30, 8'd30, 8'd34};

    localparam logic [7:0] DEF8_INTRA [64] = '{
        8'd6, 8'd10, 8'd10, 8'd13, 8'd11, 8'd13, 8'd16, 8'd16,
        8'd16, 8'd16, 8'd18, 8'd18, 8'd18, 8'd18, 8'd18, 8'd23,
        8'd23, 8'd23, 8'd23, 8'd23, 8'd23, 8'd25, 8'd25, 8'd25,
        8'd25, 8'd25, 8'd25, 8'd25, 8'd27, 8'd27, 8'd27, 8'd27,
        8'd27, 8'd27, 8'd27, 8'd27, 8'd29, 8'd29, 8'd29, 8'd29,
        8'd29, 8'd29, 8'd29, 8'd31, 8'd31, 8'd31, 8'd31, 8'd31,
        8'd31, 8'd33, 8'd33, 8'd33, 8'd33, 8'd33, 8'd36, 8'd36,
        8'd36, 8'd36, 8'd38, 8'd38, 8'd38, 8'd40, 8'd40, 8'd42};

    localparam logic [7:0] DEF8_INTER [64] = '{
        8'd9, 8'd13, 8'd13, 8'd15, 8'd13, 8'd15, 8'd17, 8'd17,
        8'd17, 8'd17, 8'd19, 8'd19, 8'd19, 8'd19, 8'd19, 8'd21,
        8'd21, 8'd21, 8'd21, 8'd21, 8'd21, 8'd22, 8'd22, 8'd22,
        8'd22, 8'd22, 8'd22, 8'd22, 8'd24, 8'd24, 8'd24, 8'd24,
        8'd24, 8'd24, 8'd24, 8'd24, 8'd25, 8'd25, 8'd25, 8'd25,
        8'd25, 8'd25, 8'd25, 8'd27, 8'd27, 8'd27, 8'd27, 8'd27,
        8'd27, 8'd28, 8'd28, 8'd28, 8'd28, 8'd28, 8'd30, 8'd30,
        8'd30, 8'd30, 8'd32, 8'd32, 8'd32, 8'd33, 8'd33, 8'd35};

    // Offset of a list in the store.
    function automatic logic [7:0] list_base(input logic [2:0] l);
        logic [7:0] b;
        if (l < 3'd6)
        begin
            b = {1'b0, l, 4'b0000};
        end
        else if (l[0])
        begin
            b = 8'd160;
        end
        else
        begin
            b = 8'd96;
        end
        return b;
    endfunction

    // Index of the last entry of a list.
    function automatic logic [5:0] list_last(input logic [2:0] l);
        return (l < 3'd6) ? 6'd15 : 6'd63;
    endfunction

    // Number of entries of a list.
    function automatic logic [6:0] list_size(input logic [2:0] l);
        return (l < 3'd6) ? 7'd16 : 7'd64;
    endfunction

    // Raster position of scan index i within list l.
    function automatic logic [5:0] scan_pos(input logic [2:0] l, input logic [5:0] i);
        return (l < 3'd6) ? {2'b00, ZZ4[i[3:0]]} : ZZ8[i];
    endfunction

    // Default value at scan index i of list l.
    function automatic logic [7:0] default_value(input logic [2:0] l, input logic [5:0] i);
        logic [7:0] d;
        if (l < 3'd3)
        begin
            d = DEF4_INTRA[i[3:0]];
        end
        else if (l < 3'd6)
        begin
            d = DEF4_INTER[i[3:0]];
        end
        else if (l[0])
        begin
            d = DEF8_INTER[i];
        end
        else
        begin
            d = DEF8_INTRA[i];
        end
        return d;
    endfunction

endpackage

[rtl/smd_in_if.sv]
interface smd_in_if;

    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic signed [7:0] value;
    logic [2:0]        read_list;
    logic [5:0]        read_pos;

    modport source (output valid, output op, output value, output read_list,
                    output read_pos, input ready);
    modport sink (input valid, input op, input value, input read_list,
                  input read_pos, output ready);

endinterface

[rtl/smd_out_if.sv]
interface smd_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] coefficient;
    logic       all_done;

    modport source (output valid, output coefficient, output all_done, input ready);
    modport sink (input valid, input coefficient, input all_done, output ready);

endinterface

[rtl/smd_ram.sv]
module smd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/scaling_matrix_decoder_core.sv]
// Scaling matrix decoder. Words on the item channel build the six 4x4 and two 8x8 scaling
// lists in a 224-byte store RAM; a read word returns one stored byte on the result
// channel. Begin-keep, flat begin (which only clears per-entry valid bits), present flags,
// and deltas that do not end a list need no store sweep. A read waits in the read-out
// state for a free result register. Each operation that rewrites a list walks the store
// RAM's single write port one entry per cycle: an absent list that loads its default, a
// list that ends, a list copy, and a default begin, which rewrites all eight lists. No
// clearing pass is needed after reset: an entry never written since reset or a flat begin
// reads as 16.
module scaling_matrix_decoder_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic            wr_index,
    input  logic            wr_data,
    smd_in_if.sink          item,
    smd_out_if.source       result
);

    // Controller states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_RD    = 2'd2;

    // Kinds of list sweep.
    localparam logic [1:0] M_DEF  = 2'd0;
    localparam logic [1:0] M_COPY = 2'd1;
    localparam logic [1:0] M_SCAT = 2'd2;

    localparam logic PH_FLAG  = 1'b0;
    localparam logic PH_DELTA = 1'b1;

    // Configuration and decode state.
    logic       use_large_reg;
    logic       keep_reg;
    logic [1:0] state_reg, state_next;
    logic       phase_reg, phase_next;
    logic [3:0] list_reg, list_next;
    logic [6:0] entry_reg, entry_next;
    logic [7:0] last_scale_reg, last_scale_next;

    // Sweep issue stage.
    logic [1:0] sw_mode_reg, sw_mode_next;
    logic       sw_chain_reg, sw_chain_next;
    logic [2:0] sw_list_reg, sw_list_next;
    logic [5:0] sw_cnt_reg, sw_cnt_next;
    logic [6:0] sw_fill_reg, sw_fill_next;

    // Sweep write stage.
    logic       pipe_vld_reg, pipe_vld_next;
    logic [1:0] pipe_mode_reg, pipe_mode_next;
    logic [2:0] pipe_list_reg, pipe_list_next;
    logic [5:0] pipe_idx_reg, pipe_idx_next;

    // Result register and read bookkeeping.
    logic       out_vld_reg, out_vld_next;
    logic [7:0] coef_reg, coef_next;
    logic       done_reg, done_next;
    logic       rd_done_reg, rd_done_next;
    logic       rd_valid_reg;

    // Per-entry written marks of the store.
    logic [smd_pkg::STORE_DEPTH-1:0] valid_reg;
    logic                            valid_clear;

    // Memory ports.
    logic                store_we, store_re;
    logic [7:0]          store_waddr, store_raddr, store_wdata, store_rdata;
    logic                stg_we, stg_re;
    logic [5:0]          stg_waddr, stg_raddr;
    logic [7:0]          stg_wdata, stg_rdata;

    // Combinational helpers.
    logic       accept;
    logic [3:0] list_count;
    logic [7:0] sum_scale;
    logic [7:0] kept_scale;
    logic [6:0] entry_inc;
    logic [2:0] cur_list;
    logic [7:0] read_addr;

    smd_ram #(.WIDTH(8), .DEPTH(smd_pkg::STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    smd_ram #(.WIDTH(8), .DEPTH(smd_pkg::STAGE_DEPTH)) u_stage (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (stg_wdata),
        .re    (stg_re),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    // Handshake and shared decode terms.
    assign item.ready    = (state_reg == S_IDLE) && !pipe_vld_reg;
    assign accept        = item.valid && item.ready;
    assign list_count    = use_large_reg ? smd_pkg::COUNT_LARGE : smd_pkg::COUNT_SMALL;
    assign cur_list      = list_reg[2:0];
    assign sum_scale     = last_scale_reg + $unsigned(item.value);
    assign kept_scale    = (sum_scale != 8'd0) ? sum_scale : last_scale_reg;
    assign entry_inc     = entry_reg + 7'd1;
    assign read_addr     = (item.read_list < 3'd6)
                         ? ({1'b0, item.read_list, 4'b0000} + {4'b0000, item.read_pos[3:0]})
                         : (smd_pkg::list_base(item.read_list) + {2'b00, item.read_pos});

    assign result.valid       = out_vld_reg;
    assign result.coefficient = coef_reg;
    assign result.all_done    = done_reg;

    // Main controller: decodes accepted words, issues sweeps and read-outs.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        list_next       = list_reg;
        entry_next      = entry_reg;
        last_scale_next = last_scale_reg;
        sw_mode_next    = sw_mode_reg;
        sw_chain_next   = sw_chain_reg;
        sw_list_next    = sw_list_reg;
        sw_cnt_next     = sw_cnt_reg;
        sw_fill_next    = sw_fill_reg;
        pipe_vld_next   = 1'b0;
        pipe_mode_next  = pipe_mode_reg;
        pipe_list_next  = pipe_list_reg;
        pipe_idx_next   = pipe_idx_reg;
        rd_done_next    = rd_done_reg;
        out_vld_next    = out_vld_reg && !result.ready;
        coef_next       = coef_reg;
        done_next       = done_reg;
        valid_clear     = 1'b0;
        store_re        = 1'b0;
        store_raddr     = read_addr;
        stg_we          = 1'b0;
        stg_waddr       = entry_reg[5:0];
        stg_wdata       = kept_scale;
        stg_re          = 1'b0;
        stg_raddr       = sw_cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.op)
                        smd_pkg::OP_BEGIN:
                        begin
                            if (item.value == 8'sd0)
                            begin
                                valid_clear = 1'b1;
                            end
                            else if (item.value == 8'sd1)
                            begin
                                sw_mode_next  = M_DEF;
                                sw_chain_next = 1'b1;
                                sw_list_next  = 3'd0;
                                sw_cnt_next   = 6'd0;
                                state_next    = S_SWEEP;
                            end
                            list_next  = 4'd0;
                            phase_next = PH_FLAG;
                        end
                        smd_pkg::OP_FLAG:
                        begin
                            if (phase_reg == PH_FLAG && list_reg < list_count)
                            begin
                                if (item.value[0])
                                begin
                                    phase_next      = PH_DELTA;
                                    entry_next      = 7'd0;
                                    last_scale_next = smd_pkg::START_SCALE;
                                end
                                else
                                begin
                                    list_next     = list_reg + 4'd1;
                                    sw_chain_next = 1'b0;
                                    sw_list_next  = cur_list;
                                    sw_cnt_next   = 6'd0;
                                    if (cur_list == 3'd0 || cur_list == 3'd3
                                        || cur_list >= 3'd6)
                                    begin
                                        sw_mode_next = M_DEF;
                                        if (!keep_reg)
                                        begin
                                            state_next = S_SWEEP;
                                        end
                                    end
                                    else
                                    begin
                                        sw_mode_next = M_COPY;
                                        state_next   = S_SWEEP;
                                    end
                                end
                            end
                        end
                        smd_pkg::OP_DELTA:
                        begin
                            if (phase_reg == PH_DELTA)
                            begin
                                sw_chain_next = 1'b0;
                                sw_list_next  = cur_list;
                                sw_cnt_next   = 6'd0;
                                if (entry_reg == 7'd0 && sum_scale == 8'd0)
                                begin
                                    // A first delta that brings the scale to zero selects the default list.
                                    sw_mode_next = M_DEF;
                                    state_next   = S_SWEEP;
                                    list_next    = list_reg + 4'd1;
                                    phase_next   = PH_FLAG;
                                end
                                else
                                begin
                                    stg_we          = 1'b1;
                                    last_scale_next = kept_scale;
                                    entry_next      = entry_inc;
                                    if (sum_scale == 8'd0
                                        || entry_inc == smd_pkg::list_size(cur_list))
                                    begin
                                        // Entries past the fill count take the last scale.
                                        sw_mode_next = M_SCAT;
                                        sw_fill_next = entry_inc;
                                        state_next   = S_SWEEP;
                                        list_next    = list_reg + 4'd1;
                                        phase_next   = PH_FLAG;
                                    end
                                end
                            end
                        end
                        smd_pkg::OP_READ:
                        begin
                            store_re     = 1'b1;
                            rd_done_next = (phase_reg == PH_FLAG) && (list_reg >= list_count);
                            state_next   = S_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                // Issue one entry: source read (if any) now, store write next cycle.
                store_re       = (sw_mode_reg == M_COPY);
                store_raddr    = {1'b0, sw_list_reg - 3'd1, 4'b0000} + {4'b0000, sw_cnt_reg[3:0]};
                stg_re         = (sw_mode_reg == M_SCAT);
                pipe_vld_next  = 1'b1;
                pipe_mode_next = sw_mode_reg;
                pipe_list_next = sw_list_reg;
                pipe_idx_next  = sw_cnt_reg;
                if (sw_cnt_reg == smd_pkg::list_last(sw_list_reg))
                begin
                    sw_cnt_next = 6'd0;
                    if (sw_chain_reg && sw_list_reg != 3'd7)
                    begin
                        sw_list_next = sw_list_reg + 3'd1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    sw_cnt_next = sw_cnt_reg + 6'd1;
                end
            end
            S_RD:
            begin
                // Store data is ready; wait for a free result register.
                if (!out_vld_reg || result.ready)
                begin
                    out_vld_next = 1'b1;
                    coef_next    = rd_valid_reg ? store_rdata : smd_pkg::FLAT_VALUE;
                    done_next    = rd_done_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sweep write stage into the store.
    always_comb
    begin
        store_we    = pipe_vld_reg;
        store_waddr = smd_pkg::list_base(pipe_list_reg)
                    + {2'b00, smd_pkg::scan_pos(pipe_list_reg, pipe_idx_reg)};
        store_wdata = smd_pkg::default_value(pipe_list_reg, pipe_idx_reg);
        case (pipe_mode_reg)
            M_COPY:
            begin
                store_waddr = smd_pkg::list_base(pipe_list_reg)
                            + {4'b0000, pipe_idx_reg[3:0]};
                store_wdata = rd_valid_reg ? store_rdata : smd_pkg::FLAT_VALUE;
            end
            M_SCAT:
            begin
                store_wdata = ({1'b0, pipe_idx_reg} < sw_fill_reg) ? stg_rdata : last_scale_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_large_reg  <= 1'b1;
            keep_reg       <= 1'b0;
            state_reg      <= S_IDLE;
            phase_reg      <= PH_FLAG;
            list_reg       <= 4'd0;
            entry_reg      <= 7'd0;
            last_scale_reg <= smd_pkg::START_SCALE;
            sw_mode_reg    <= M_DEF;
            sw_chain_reg   <= 1'b0;
            sw_list_reg    <= 3'd0;
            sw_cnt_reg     <= 6'd0;
            pipe_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    smd_pkg::REG_USE_LARGE: use_large_reg <= wr_data;
                    smd_pkg::REG_KEEP:      keep_reg      <= wr_data;
                    default:
                    begin
                    end
                endcase
            end
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            list_reg       <= list_next;
            entry_reg      <= entry_next;
            last_scale_reg <= last_scale_next;
            sw_mode_reg    <= sw_mode_next;
            sw_chain_reg   <= sw_chain_next;
            sw_list_reg    <= sw_list_next;
            sw_cnt_reg     <= sw_cnt_next;
            pipe_vld_reg   <= pipe_vld_next;
            out_vld_reg    <= out_vld_next;
            if (valid_clear)
            begin
                valid_reg <= '0;
            end
            else if (store_we)
            begin
                valid_reg[store_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sw_fill_reg    <= sw_fill_next;
        pipe_mode_reg  <= pipe_mode_next;
        pipe_list_reg  <= pipe_list_next;
        pipe_idx_reg   <= pipe_idx_next;
        rd_done_reg    <= rd_done_next;
        coef_reg       <= coef_next;
        done_reg       <= done_next;
        if (store_re)
        begin
            rd_valid_reg <= valid_reg[store_raddr];
        end
    end

    // The store is never written beyond its last entry.
    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> (store_waddr < 8'(smd_pkg::STORE_DEPTH)))
        else $error("store write beyond last entry");

    // A read word always moves to the read-out state.
    a_read_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.op == smd_pkg::OP_READ) |=> (state_reg == S_RD))
        else $error("read word did not start a read-out");

    // The list counter never passes the largest set.
    a_list_range: assert property (@(posedge clk) disable iff (!rst_n)
        list_reg <= smd_pkg::COUNT_LARGE)
        else $error("list counter out of range");

    // Deltas are only taken for an existing list.
    a_delta_list: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DELTA) |-> (list_reg < smd_pkg::COUNT_LARGE))
        else $error("delta phase without a list");

    // Staging writes stay inside the staging buffer.
    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        stg_we |-> !entry_reg[6])
        else $error("staging write beyond buffer");

    // A sweep write stage never overlaps an accepted word.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_vld_reg |-> !accept)
        else $error("word accepted during a store write-back");

endmodule

[bench/tb_top.sv]
module tb_top;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 300;
    localparam int LONG_HOLD      = 500;
    localparam int CYCLE_LIMIT    = 1500000;
    localparam int DIRECTED_WORDS = 25;
    localparam int RANDOM_WORDS   = 575;
    localparam int STALL_LEVELS [4] = '{0, 20, 50, 85};
    localparam logic SETTING_LARGE [4] = '{1'b0, 1'b1, 1'b0, 1'b1};
    localparam logic SETTING_KEEP  [4] = '{1'b1, 1'b1, 1'b0, 1'b0};

    typedef enum logic {AWAIT_FLAG, AWAIT_DELTA} decode_phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] value;
        logic [2:0] read_list;
        logic [5:0] read_pos;
    } word_t;

    typedef struct packed {
        logic [7:0] coefficient;
        logic       all_done;
    } coef_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;
    logic wr_en;
    logic wr_index;
    logic wr_data;

    smd_in_if  item_if();
    smd_out_if result_if();

    scaling_matrix_decoder_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .item     (item_if),
        .result   (result_if)
    );

    // Words waiting to be sent and coefficients waiting to come back.
    word_t pending_words [$];
    coef_t coef_expected [$];

    // Mirror of the decoder state and its registers.
    logic [7:0]    model_store [smd_pkg::STORE_DEPTH];
    logic [7:0]    staged [smd_pkg::STAGE_DEPTH];
    logic [3:0]    cur_list;
    logic [6:0]    cur_entry;
    logic [7:0]    held_scale;
    decode_phase_t cur_phase;
    logic          cfg_large;
    logic          cfg_keep;

    int words_queued;
    int words_accepted;
    int reads_checked;
    int begins_seen;
    int mismatches;
    int cycle_count;
    int phase_no;

    int    burst_left;
    int    gap_left;
    word_t next_word;
    word_t seen;
    coef_t want;

    logic hold_req;
    int   hold_left;
    int   pattern_left;
    int   stall_pct;

    always
    begin
        #HALF_PERIOD clk = ~clk;
    end

    // Offset of a list in the store.
    function automatic int list_offset(input int l);
        return (l < 6) ? l * 16 : 96 + (l % 2) * 64;
    endfunction

    // Write list l through its zigzag scan, from its default table or from the staged values.
    function automatic void write_list(input int l, input bit from_default);
        int n;
        int i;
        int pos;
        logic [7:0] v;
        n = (l < 6) ? 16 : 64;
        for (i = 0; i < n; i++)
        begin
            if (l < 6)
            begin
                pos = int'(smd_pkg::ZZ4[i]);
            end
            else
            begin
                pos = int'(smd_pkg::ZZ8[i]);
            end
            if (!from_default)
            begin
                v = staged[i];
            end
            else if (l < 3)
            begin
                v = smd_pkg::DEF4_INTRA[i];
            end
            else if (l < 6)
            begin
                v = smd_pkg::DEF4_INTER[i];
            end
            else if (l % 2 == 1)
            begin
                v = smd_pkg::DEF8_INTER[i];
            end
            else
            begin
                v = smd_pkg::DEF8_INTRA[i];
            end
            model_store[list_offset(l) + pos] = v;
        end
    endfunction

    // Advance the mirrored decoder by one accepted word.
    function automatic void predict_word(input word_t w);
        int l;
        int n;
        int e;
        int k;
        int count;
        int addr;
        logic [7:0] nxt;
        coef_t r;
        l = int'(cur_list);
        count = cfg_large ? 6 + smd_pkg::LARGE_LIST_COUNT : 6;
        case (w.op)
            smd_pkg::OP_BEGIN:
            begin
                begins_seen++;
                if (w.value == 8'd0)
                begin
                    for (k = 0; k < smd_pkg::STORE_DEPTH; k++)
                    begin
                        model_store[k] = smd_pkg::FLAT_VALUE;
                    end
                end
                else if (w.value == 8'd1)
                begin
                    for (k = 0; k < 8; k++)
                    begin
                        write_list(k, 1'b1);
                    end
                end
                cur_list = '0;
                cur_phase = AWAIT_FLAG;
            end
            smd_pkg::OP_FLAG:
            begin
                if (cur_phase == AWAIT_FLAG && l < count)
                begin
                    if (w.value[0])
                    begin
                        cur_phase = AWAIT_DELTA;
                        cur_entry = '0;
                        held_scale = smd_pkg::START_SCALE;
                    end
                    else
                    begin
                        if (l == 0 || l == 3 || l >= 6)
                        begin
                            if (!cfg_keep)
                            begin
                                write_list(l, 1'b1);
                            end
                        end
                        else
                        begin
                            for (k = 0; k < 16; k++)
                            begin
                                model_store[l * 16 + k] = model_store[(l - 1) * 16 + k];
                            end
                        end
                        cur_list = cur_list + 4'd1;
                    end
                end
            end
            smd_pkg::OP_DELTA:
            begin
                if (cur_phase == AWAIT_DELTA && l < 8)
                begin
                    n = (l < 6) ? 16 : 64;
                    e = int'(cur_entry);
                    nxt = held_scale + w.value;
                    if (e == 0 && nxt == 8'd0)
                    begin
                        // A zero first scale selects the default list.
                        write_list(l, 1'b1);
                        cur_list = cur_list + 4'd1;
                        cur_phase = AWAIT_FLAG;
                    end
                    else
                    begin
                        if (nxt != 8'd0)
                        begin
                            held_scale = nxt;
                        end
                        if (e < 64)
                        begin
                            staged[e] = held_scale;
                        end
                        e++;
                        // A later zero repeats the last value to the end of the list.
                        if (nxt == 8'd0)
                        begin
                            while (e < n)
                            begin
                                staged[e] = held_scale;
                                e++;
                            end
                        end
                        cur_entry = 7'(e);
                        if (e >= n)
                        begin
                            write_list(l, 1'b0);
                            cur_list = cur_list + 4'd1;
                            cur_phase = AWAIT_FLAG;
                        end
                    end
                end
            end
            smd_pkg::OP_READ:
            begin
                if (w.read_list < 3'd6)
                begin
                    addr = int'(w.read_list) * 16 + int'(w.read_pos[3:0]);
                end
                else
                begin
                    addr = list_offset(int'(w.read_list)) + int'(w.read_pos);
                end
                r.coefficient = model_store[addr];
                r.all_done = (cur_phase == AWAIT_FLAG && int'(cur_list) >= count);
                coef_expected.push_back(r);
            end
        endcase
    endfunction

    // Stimulus helpers.
    task automatic queue_word(input logic [1:0] op, input logic [7:0] value);
        word_t w;
        w.op = op;
        w.value = value;
        w.read_list = 3'($urandom_range(0, 7));
        w.read_pos = 6'($urandom_range(0, 63));
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_read_at(input logic [2:0] rl, input logic [5:0] rp);
        word_t w;
        w.op = smd_pkg::OP_READ;
        w.value = 8'($urandom_range(0, 255));
        w.read_list = rl;
        w.read_pos = rp;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic queue_read();
        queue_word(smd_pkg::OP_READ, 8'($urandom_range(0, 255)));
    endtask

    // A present list: the flag, then deltas that may end early on a zero.
    task automatic queue_present_list(input int size);
        int style;
        int cut;
        int i;
        logic [7:0] run;
        logic [7:0] d;
        logic [7:0] nxt;
        style = $urandom_range(0, 9);
        queue_word(smd_pkg::OP_FLAG, {7'($urandom_range(0, 127)), 1'b1});
        run = smd_pkg::START_SCALE;
        if (style == 0)
        begin
            queue_word(smd_pkg::OP_DELTA, 8'(0) - run);
            return;
        end
        cut = size;
        if (style <= 3 || (size == 64 && style != 7 && style != 9))
        begin
            cut = (size == 16) ? $urandom_range(1, 15) : $urandom_range(1, 12);
        end
        for (i = 0; i < cut; i++)
        begin
            if (style >= 8)
            begin
                d = 8'($urandom_range(0, 255));
            end
            else
            begin
                d = 8'($urandom_range(0, 32) - 16);
            end
            nxt = run + d;
            if (nxt == 8'd0)
            begin
                d = d + 8'd1;
            end
            run = run + d;
            queue_word(smd_pkg::OP_DELTA, d);
            if ($urandom_range(0, 19) == 0)
            begin
                queue_read();
            end
        end
        if (cut < size)
        begin
            queue_word(smd_pkg::OP_DELTA, 8'(0) - run);
        end
    endtask

    // One set of lists after a begin; a partial set stops short of the last list.
    task automatic queue_set(input bit partial);
        int count;
        int lists;
        int k;
        int r;
        count = cfg_large ? 6 + smd_pkg::LARGE_LIST_COUNT : 6;
        lists = partial ? $urandom_range(5, count - 1) : count;
        r = $urandom_range(0, 2);
        queue_word(smd_pkg::OP_BEGIN, (r == 2) ? 8'($urandom_range(2, 255)) : 8'(r));
        for (k = 0; k < lists; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                // An abandoned list: the next begin cuts it short.
                queue_word(smd_pkg::OP_FLAG, 8'h01);
                repeat ($urandom_range(1, 3))
                    queue_word(smd_pkg::OP_DELTA, 8'($urandom_range(1, 7)));
                queue_read();
                return;
            end
            else if (r < 40)
            begin
                queue_word(smd_pkg::OP_FLAG, {7'($urandom_range(0, 127)), 1'b0});
            end
            else
            begin
                queue_present_list((k < 6) ? 16 : 64);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                queue_read();
            end
            if ($urandom_range(0, 29) == 0)
            begin
                queue_word(($urandom_range(0, 1) == 1) ? smd_pkg::OP_FLAG : smd_pkg::OP_DELTA,
                           8'($urandom_range(0, 255)));
            end
        end
        if (!partial)
        begin
            // Words out of turn once the set is complete.
            if ($urandom_range(0, 1) == 1)
            begin
                queue_word(smd_pkg::OP_FLAG, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 1)
            begin
                queue_word(smd_pkg::OP_DELTA, 8'($urandom_range(0, 255)));
            end
        end
        repeat ($urandom_range(4, 10)) queue_read();
    endtask

    // Wait until every word is sent and every coefficient is back, then let the store settle.
    task automatic wait_idle();
        while (pending_words.size() != 0 || item_if.valid || coef_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == smd_pkg::REG_USE_LARGE)
        begin
            cfg_large = val;
        end
        else
        begin
            cfg_keep = val;
        end
    endtask

    // Sender: bursts of words with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_if.valid <= 1'b0;
            item_if.op <= smd_pkg::OP_BEGIN;
            item_if.value <= '0;
            item_if.read_list <= '0;
            item_if.read_pos <= '0;
            burst_left = $urandom_range(1, 40);
            gap_left = 0;
        end
        else if (!item_if.valid || item_if.ready)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                item_if.valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                next_word = pending_words.pop_front();
                item_if.valid <= 1'b1;
                item_if.op <= next_word.op;
                item_if.value <= next_word.value;
                item_if.read_list <= next_word.read_list;
                item_if.read_pos <= next_word.read_pos;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall level changes every so often; a requested hold blocks it for long.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            hold_left <= 0;
            pattern_left <= 0;
            stall_pct <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_if.ready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_left <= LONG_HOLD;
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                pattern_left <= $urandom_range(20, 200);
                stall_pct <= STALL_LEVELS[$urandom_range(0, 3)];
            end
            else
            begin
                pattern_left <= pattern_left - 1;
            end
            result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor: predict on every accepted word, check every accepted coefficient.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_if.valid && item_if.ready)
            begin
                seen.op = item_if.op;
                seen.value = item_if.value;
                seen.read_list = item_if.read_list;
                seen.read_pos = item_if.read_pos;
                predict_word(seen);
                words_accepted++;
            end
            if (result_if.valid && result_if.ready)
            begin
                if (coef_expected.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %0d all_done %0b",
                             $time, result_if.coefficient, result_if.all_done);
                    mismatches++;
                end
                else
                begin
                    want = coef_expected.pop_front();
                    if (result_if.coefficient !== want.coefficient)
                    begin
                        $display("%0t: coefficient expected %0d, actual %0d",
                                 $time, want.coefficient, result_if.coefficient);
                        mismatches++;
                    end
                    if (result_if.all_done !== want.all_done)
                    begin
                        $display("%0t: all_done expected %0b, actual %0b",
                                 $time, want.all_done, result_if.all_done);
                        mismatches++;
                    end
                    reads_checked++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        int k;
        wr_en = 1'b0;
        wr_index = smd_pkg::REG_USE_LARGE;
        wr_data = 1'b0;
        hold_req = 1'b0;
        words_queued = 0;
        words_accepted = 0;
        reads_checked = 0;
        begins_seen = 0;
        mismatches = 0;
        cycle_count = 0;
        for (k = 0; k < smd_pkg::STORE_DEPTH; k++)
        begin
            model_store[k] = smd_pkg::FLAT_VALUE;
        end
        for (k = 0; k < smd_pkg::STAGE_DEPTH; k++)
        begin
            staged[k] = '0;
        end
        cur_list = '0;
        cur_entry = '0;
        held_scale = smd_pkg::START_SCALE;
        cur_phase = AWAIT_FLAG;
        cfg_large = 1'b1;
        cfg_keep = 1'b0;

        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        write_register(smd_pkg::REG_USE_LARGE, 1'b1);
        write_register(smd_pkg::REG_KEEP, 1'b0);

        // Directed: reset contents, default begin, delta extremes and both zero cases.
        queue_read_at(3'd0, 6'd0);
        queue_word(smd_pkg::OP_BEGIN, 8'd1);
        queue_read_at(3'd7, 6'd63);
        queue_word(smd_pkg::OP_FLAG, 8'h01);
        queue_word(smd_pkg::OP_DELTA, 8'd127);
        queue_word(smd_pkg::OP_DELTA, 8'h80);
        queue_word(smd_pkg::OP_DELTA, 8'hF9);
        queue_word(smd_pkg::OP_FLAG, 8'hFF);
        queue_word(smd_pkg::OP_FLAG, 8'h00);
        queue_word(smd_pkg::OP_DELTA, 8'hF8);
        queue_word(smd_pkg::OP_FLAG, 8'hFE);
        queue_word(smd_pkg::OP_FLAG, 8'h00);
        queue_word(smd_pkg::OP_FLAG, 8'h00);
        queue_word(smd_pkg::OP_FLAG, 8'h00);
        queue_word(smd_pkg::OP_FLAG, 8'h01);
        queue_word(smd_pkg::OP_DELTA, 8'h00);
        queue_word(smd_pkg::OP_DELTA, 8'hF8);
        queue_word(smd_pkg::OP_FLAG, 8'h00);
        queue_word(smd_pkg::OP_FLAG, 8'h01);
        queue_word(smd_pkg::OP_DELTA, 8'h05);
        queue_read_at(3'd3, 6'd31);
        queue_read_at(3'd6, 6'd0);
        queue_word(smd_pkg::OP_BEGIN, 8'd0);
        queue_word(smd_pkg::OP_BEGIN, 8'h80);
        queue_read_at(3'd5, 6'd17);

        // Random phases, each under its own register setting.
        phase_no = 0;
        while (words_queued < DIRECTED_WORDS + RANDOM_WORDS)
        begin
            wait_idle();
            write_register(smd_pkg::REG_USE_LARGE, SETTING_LARGE[phase_no % 4]);
            write_register(smd_pkg::REG_KEEP, SETTING_KEEP[phase_no % 4]);
            // See where an unfinished set stands after the list count has changed.
            repeat (3) queue_read();
            repeat (2) queue_word(smd_pkg::OP_FLAG, 8'($urandom_range(0, 255)));
            queue_read();
            if (phase_no == 0)
            begin
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
                repeat (60) queue_read();
            end
            repeat ($urandom_range(1, 2)) queue_set(1'b0);
            if (phase_no % 2 == 1)
            begin
                queue_set(1'b1);
            end
            phase_no++;
        end
        wait_idle();

        $display("Covered %0d words (%0d begins) across %0d register settings.",
                 words_accepted, begins_seen, phase_no + 1);
        $display("Checked %0d coefficients, %0d mismatches.", reads_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
